// ----- hw/rtl/osvm_pkg.sv -----
package osvm_pkg;

  // Item codes carried on the kind field
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RATE_STEP     = 2'd0,
    REG_LEVEL         = 2'd1,
    REG_DECAY_FACTOR  = 2'd2,
    REG_SAMPLE_LENGTH = 2'd3
  } reg_index_t;

  localparam int RATE_W   = 18;
  localparam int LEVEL_W  = 16;
  localparam int DECAY_W  = 17;
  localparam int LENGTH_W = 13;
  localparam int CFG_W    = 18;
  localparam int INDEX_W  = 12;
  localparam int PCM_W    = 16;
  localparam int ENV_W    = 17;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd65536;
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 16'd8192;
  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 17'd65536;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 13'd4096;

  localparam logic [ENV_W-1:0]   ENV_ONE   = 17'h10000;
  localparam logic [DECAY_W-1:0] DECAY_MAX = 17'h10000;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [RATE_W-1:0]   rate_step;
    logic [LEVEL_W-1:0]  level;
    logic [DECAY_W-1:0]  decay_factor;
    logic [LENGTH_W-1:0] sample_length;
  } cfg_t;

  typedef struct packed {
    kind_t                     kind;
    logic [INDEX_W-1:0]        index;
    logic signed [PCM_W-1:0]   value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } eng_state_t;

endpackage

// ----- hw/rtl/one_shot_sample_voice_mixer_unit.sv -----
// One-shot sample voice mixer: VOICES voices play from a shared PCM sample memory.
// Item channel (item_valid / item_stall): kind 0 loads one word into sample memory,
// kind 1 marks the next voice in round-robin order for restart, kind 2 is an output
// tick; kind 3 and loads past the memory are taken and dropped.
// Result channel (result_valid / result_stall): one mixed_sample per tick, nothing else.
// Configuration: cfg_write with cfg_index / cfg_data, only while the block is idle.
// Items go through a two-entry queue into the voice engine, so the item side keeps
// flowing while a result waits on a stalled receiver.
// A load or trigger is handled as the engine pops it. A tick walks the voices one per
// cycle through a five-stage voice pipeline; the engine pops no further item until
// the tick's result is loaded into the output register, so the voice walk sets the
// tick rate.
// While the receiver stalls, the result holds in the output register and the engine
// stops before finishing the next tick; the queue then fills and raises item_stall.
// Reset (rst, synchronous): all voices idle, nothing pending, trigger pointer at
// voice 0, registers to their defaults; sample memory keeps whatever it held.
module one_shot_sample_voice_mixer_unit #(
  parameter int VOICES       = 32,
  parameter int SAMPLE_DEPTH = 4096,
  parameter int FRAC_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         kind,
  input  logic [osvm_pkg::INDEX_W-1:0]       sample_index,
  input  logic signed [osvm_pkg::PCM_W-1:0]  sample_value,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [osvm_pkg::PCM_W-1:0]  mixed_sample,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [osvm_pkg::CFG_W-1:0]         cfg_data
);
  import osvm_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers: truncate the write data to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_step     <= RATE_RESET;
      cfg.level         <= LEVEL_RESET;
      cfg.decay_factor  <= DECAY_RESET;
      cfg.sample_length <= LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RATE_STEP:     cfg.rate_step     <= cfg_data[RATE_W-1:0];
        REG_LEVEL:         cfg.level         <= cfg_data[LEVEL_W-1:0];
        REG_DECAY_FACTOR:  cfg.decay_factor  <= cfg_data[DECAY_W-1:0];
        REG_SAMPLE_LENGTH: cfg.sample_length <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept, classify and queue items
  osvm_front #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: sample memory, voice state and the mixing pipeline
  osvm_engine #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mixed_sample (mixed_sample)
  );

endmodule

// ----- hw/rtl/osvm_queue.sv -----
module osvm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  osvm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output osvm_pkg::cmd_t head
);
  import osvm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/osvm_front.sv -----
module osvm_front #(
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  kind,
  input  logic [osvm_pkg::INDEX_W-1:0] sample_index,
  input  logic signed [osvm_pkg::PCM_W-1:0] sample_value,
  output logic                        cmd_valid,
  output osvm_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);
  import osvm_pkg::*;

  logic full;
  logic accept;
  logic keep;
  cmd_t push_data;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  // Drop unknown kinds and loads outside the sample memory
  always_comb begin
    push_data.kind  = kind_t'(kind);
    push_data.index = sample_index;
    push_data.value = sample_value;
    unique case (kind)
      KIND_LOAD:    keep = (32'(sample_index) < 32'(SAMPLE_DEPTH));
      KIND_TRIGGER: keep = 1'b1;
      KIND_TICK:    keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  osvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && keep),
    .push_data (push_data),
    .full      (full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (cmd)
  );

endmodule

// ----- hw/rtl/osvm_engine.sv -----
module osvm_engine #(
  parameter int VOICES       = 32,
  parameter int SAMPLE_DEPTH = 4096,
  parameter int FRAC_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  osvm_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  input  osvm_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [osvm_pkg::PCM_W-1:0] mixed_sample
);
  import osvm_pkg::*;

  localparam int AW        = $clog2(SAMPLE_DEPTH);
  localparam int LEN_W     = $clog2(SAMPLE_DEPTH + 1);
  localparam int CMP_W     = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 1;
  localparam int POS_W     = AW + FRAC_BITS;
  localparam int PSUM_W    = ((POS_W > RATE_W) ? POS_W : RATE_W) + 1;
  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IP_W      = PCM_W + 2 + FRAC_BITS;
  localparam int SL_W      = 32;
  localparam int MIX_W     = SL_W + ENV_W + 1;
  localparam int SHIFT     = 29;
  localparam int CONTRIB_W = MIX_W - SHIFT;
  localparam int ACC_W     = CONTRIB_W + VW + 1;
  localparam logic [PSUM_W-1:0] POS_MAX =
    PSUM_W'((longint'(SAMPLE_DEPTH) << FRAC_BITS) - longint'(1));
  localparam logic signed [ACC_W-1:0] FULL_POS = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] FULL_NEG = -ACC_W'(32767);

  eng_state_t state;
  eng_state_t state_next;
  logic       issue;
  logic       out_load;
  logic       out_free;
  logic       pipe_empty;

  // Stores
  logic signed [PCM_W-1:0] sample_mem [SAMPLE_DEPTH];
  logic [POS_W-1:0]        pos_mem [VOICES];
  logic [ENV_W-1:0]        env_mem [VOICES];
  logic [VOICES-1:0]       active;
  logic [VOICES-1:0]       pending;
  logic [VW-1:0]           next_voice;
  logic [VW-1:0]           vcnt;

  // Per-tick settings
  logic [LEN_W-1:0]   len_m1;
  logic [DECAY_W-1:0] dec;
  logic [CMP_W-1:0]   len_ext;
  logic [LEN_W-1:0]   len_eff;

  // Stage 1: voice state read
  logic             st1_vld;
  logic [VW-1:0]    st1_voice;
  logic             st1_restart;
  logic             st1_live;
  logic [POS_W-1:0] pos_rd;
  logic [ENV_W-1:0] env_rd;
  logic [POS_W-1:0] pos_cur;
  logic [ENV_W-1:0] env_cur;
  logic [AW-1:0]    sidx;
  logic [AW-1:0]    sidx1;
  logic             ends;
  logic             keep;
  logic             voice_end;
  logic [PSUM_W-1:0] psum;
  logic [POS_W-1:0] pos_new;

  // Stage 2: sample pair read
  logic                    st2_vld;
  logic [VW-1:0]           st2_voice;
  logic [ENV_W-1:0]        st2_env;
  logic [FRAC_BITS-1:0]    st2_frac;
  logic signed [PCM_W-1:0] rd_a;
  logic signed [PCM_W-1:0] rd_b;
  logic signed [PCM_W:0]   diff;
  logic signed [FRAC_BITS:0] frac_s;
  logic [2*ENV_W-1:0]      env_prod;

  // Stage 3: interpolation product
  logic                    st3_vld;
  logic signed [IP_W-1:0]  ip_prod;
  logic signed [PCM_W-1:0] st3_a;
  logic [ENV_W-1:0]        st3_env;
  logic signed [IP_W-1:0]  ip_shift;
  logic signed [PCM_W:0]   interp17;
  logic signed [PCM_W-1:0] interp;
  logic signed [LEVEL_W:0] level_s;
  logic signed [PCM_W+LEVEL_W:0] sl_full;

  // Stage 4: sample times level
  logic                   st4_vld;
  logic signed [SL_W-1:0] st4_sl;
  logic [ENV_W-1:0]       st4_env;
  logic signed [ENV_W:0]  env_s;

  // Stage 5: times envelope
  logic                    st5_vld;
  logic signed [MIX_W-1:0] st5_mix;

  logic signed [ACC_W-1:0] acc;
  logic signed [PCM_W-1:0] clamped;

  assign out_free   = !result_valid || !result_stall;
  assign pipe_empty = !st1_vld && !st2_vld && !st3_vld && !st4_vld && !st5_vld;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == KIND_TICK) begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (vcnt == VW'(VOICES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Clamp length to [2, SAMPLE_DEPTH]
  always_comb begin
    len_ext = CMP_W'(cfg.sample_length);
    if (len_ext < CMP_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (len_ext > CMP_W'(SAMPLE_DEPTH)) begin
      len_eff = LEN_W'(SAMPLE_DEPTH);
    end else begin
      len_eff = len_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == KIND_TICK) begin
      len_m1 <= len_eff - 1'b1;
      dec    <= (cfg.decay_factor > DECAY_MAX) ? DECAY_MAX : cfg.decay_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
    end else if (cmd_pop && cmd.kind == KIND_TICK) begin
      vcnt <= '0;
    end else if (issue) begin
      vcnt <= vcnt + 1'b1;
    end
  end

  // Voice flags and trigger pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      pending    <= '0;
      next_voice <= '0;
    end else begin
      if (cmd_pop && cmd.kind == KIND_TRIGGER) begin
        pending[next_voice] <= 1'b1;
        next_voice <= (next_voice == VW'(VOICES - 1)) ? '0 : next_voice + 1'b1;
      end
      if (issue) begin
        active[vcnt]  <= active[vcnt] | pending[vcnt];
        pending[vcnt] <= 1'b0;
      end
      if (voice_end) begin
        active[st1_voice] <= 1'b0;
      end
    end
  end

  // Voice state memories
  always_ff @(posedge clk) begin
    if (keep) begin
      pos_mem[st1_voice] <= pos_new;
    end
    if (issue) begin
      pos_rd <= pos_mem[vcnt];
    end
  end

  always_ff @(posedge clk) begin
    if (st2_vld) begin
      env_mem[st2_voice] <= env_prod[ENV_W+15:16];
    end
    if (issue) begin
      env_rd <= env_mem[vcnt];
    end
  end

  // Stage 1: end test, position advance, sample pair address
  always_comb begin
    pos_cur   = st1_restart ? '0 : pos_rd;
    env_cur   = st1_restart ? ENV_ONE : env_rd;
    sidx      = pos_cur[POS_W-1:FRAC_BITS];
    sidx1     = sidx + 1'b1;
    ends      = (LEN_W'(sidx) >= len_m1);
    keep      = st1_vld && st1_live && !ends;
    voice_end = st1_vld && st1_live && ends;
    psum      = PSUM_W'(pos_cur) + PSUM_W'(cfg.rate_step);
    pos_new   = (psum > POS_MAX) ? POS_MAX[POS_W-1:0] : psum[POS_W-1:0];
  end

  // Sample memory: one write port for loads, two read ports for the pair
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == KIND_LOAD) begin
      sample_mem[AW'(cmd.index)] <= cmd.value;
    end
    if (keep) begin
      rd_a <= sample_mem[sidx];
      rd_b <= sample_mem[sidx1];
    end
  end

  always_comb begin
    diff     = {rd_b[PCM_W-1], rd_b} - {rd_a[PCM_W-1], rd_a};
    frac_s   = {1'b0, st2_frac};
    env_prod = (2*ENV_W)'(st2_env) * (2*ENV_W)'(dec);
    ip_shift = ip_prod >>> FRAC_BITS;
    interp17 = {st3_a[PCM_W-1], st3_a} + ip_shift[PCM_W:0];
    interp   = interp17[PCM_W-1:0];
    level_s  = {1'b0, cfg.level};
    sl_full  = interp * level_s;
    env_s    = {1'b0, st4_env};
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    st1_voice   <= vcnt;
    st1_restart <= pending[vcnt];
    st1_live    <= active[vcnt] | pending[vcnt];
    st2_voice   <= st1_voice;
    st2_env     <= env_cur;
    st2_frac    <= pos_cur[FRAC_BITS-1:0];
    ip_prod     <= diff * frac_s;
    st3_a       <= rd_a;
    st3_env     <= st2_env;
    st4_sl      <= sl_full[SL_W-1:0];
    st4_env     <= st3_env;
    st5_mix     <= st4_sl * env_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld <= 1'b0;
      st2_vld <= 1'b0;
      st3_vld <= 1'b0;
      st4_vld <= 1'b0;
      st5_vld <= 1'b0;
    end else begin
      st1_vld <= issue;
      st2_vld <= keep;
      st3_vld <= st2_vld;
      st4_vld <= st3_vld;
      st5_vld <= st4_vld;
    end
  end

  // Accumulate contributions, floor by the level and envelope scale
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == KIND_TICK) begin
      acc <= '0;
    end else if (st5_vld) begin
      acc <= acc + {{(ACC_W-CONTRIB_W){st5_mix[MIX_W-1]}}, st5_mix[MIX_W-1:SHIFT]};
    end
  end

  always_comb begin
    if (acc > FULL_POS) begin
      clamped = FULL_POS[PCM_W-1:0];
    end else if (acc < FULL_NEG) begin
      clamped = FULL_NEG[PCM_W-1:0];
    end else begin
      clamped = acc[PCM_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mixed_sample <= clamped;
    end
  end

endmodule

// ----- verif/voice_mix_checker.sv -----
module voice_mix_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  logic                               item_stall,
  input  logic [1:0]                         kind,
  input  logic [osvm_pkg::INDEX_W-1:0]       sample_index,
  input  logic signed [osvm_pkg::PCM_W-1:0]  sample_value,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic signed [osvm_pkg::PCM_W-1:0]  mixed_sample,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [osvm_pkg::CFG_W-1:0]         cfg_data,
  output int                                 fail_count,
  output int                                 pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import osvm_pkg::*;

  localparam int     VOICE_COUNT = 32;
  localparam int     MEM_DEPTH   = 4096;
  localparam int     FRAC_W      = 16;
  localparam int     POS_W       = 28;
  localparam int     MIX_SHIFT   = 29;
  localparam longint FULL_SCALE  = 32767;
  localparam longint POS_MAX     = (longint'(MEM_DEPTH) << FRAC_W) - 1;

  logic [RATE_W-1:0]       rate_q;
  logic [LEVEL_W-1:0]      level_q;
  logic [DECAY_W-1:0]      decay_q;
  logic [LENGTH_W-1:0]     length_q;

  logic signed [PCM_W-1:0] pcm_mem [MEM_DEPTH];
  logic [POS_W-1:0]        voice_pos [VOICE_COUNT];
  logic [ENV_W-1:0]        voice_env [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]  voice_on;
  logic [VOICE_COUNT-1:0]  voice_armed;
  logic [4:0]              trigger_ptr;

  logic signed [PCM_W-1:0] expected_mix [$];
  logic signed [PCM_W-1:0] want;

  // Restart armed voices, sum every live voice, then advance positions and envelopes.
  function automatic logic signed [PCM_W-1:0] mix_tick();
    longint eff_len, eff_decay, acc, idx, a, b, frac, s, gain, env, pos, step;
    int v;
    eff_len = length_q;
    if (eff_len < 2) eff_len = 2;
    if (eff_len > MEM_DEPTH) eff_len = MEM_DEPTH;
    eff_decay = (decay_q > DECAY_MAX) ? DECAY_MAX : decay_q;
    gain = level_q;
    step = rate_q;
    acc = 0;
    for (v = 0; v < VOICE_COUNT; v++) begin
      if (voice_armed[v]) begin
        voice_armed[v] = 1'b0;
        voice_on[v]    = 1'b1;
        voice_pos[v]   = '0;
        voice_env[v]   = ENV_ONE;
      end
    end
    for (v = 0; v < VOICE_COUNT; v++) begin
      if (voice_on[v]) begin
        pos = voice_pos[v];
        idx = pos >> FRAC_W;
        if (idx + 1 >= eff_len) begin
          voice_on[v] = 1'b0;
        end else begin
          a    = pcm_mem[idx];
          b    = pcm_mem[idx + 1];
          frac = pos & ((longint'(1) << FRAC_W) - 1);
          s    = a + (((b - a) * frac) >>> FRAC_W);
          env  = voice_env[v];
          acc += (s * gain * env) >>> MIX_SHIFT;
        end
      end
    end
    if (acc > FULL_SCALE) acc = FULL_SCALE;
    if (acc < -FULL_SCALE) acc = -FULL_SCALE;
    for (v = 0; v < VOICE_COUNT; v++) begin
      if (voice_on[v]) begin
        pos = voice_pos[v];
        pos = pos + step;
        if (pos > POS_MAX) pos = POS_MAX;
        voice_pos[v] = pos[POS_W-1:0];
        env = voice_env[v];
        env = (env * eff_decay) >> 16;
        voice_env[v] = env[ENV_W-1:0];
      end
    end
    return acc[PCM_W-1:0];
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rate_q      = RATE_RESET;
      level_q     = LEVEL_RESET;
      decay_q     = DECAY_RESET;
      length_q    = LENGTH_RESET;
      voice_on    = '0;
      voice_armed = '0;
      trigger_ptr = '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        voice_pos[v] = '0;
        voice_env[v] = '0;
      end
      expected_mix.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RATE_STEP:     rate_q   = cfg_data[RATE_W-1:0];
          REG_LEVEL:         level_q  = cfg_data[LEVEL_W-1:0];
          REG_DECAY_FACTOR:  decay_q  = cfg_data[DECAY_W-1:0];
          REG_SAMPLE_LENGTH: length_q = cfg_data[LENGTH_W-1:0];
          default: ;
        endcase
      end
      // a result always belongs to a tick taken at an earlier edge
      if (result_valid && !result_stall) begin
        if (expected_mix.size() == 0) begin
          $error("mixed_sample: no tick waiting, actual %0d", mixed_sample);
          fail_count++;
        end else begin
          want = expected_mix.pop_front();
          if (mixed_sample !== want) begin
            $error("mixed_sample mismatch: expected %0d, actual %0d", want, mixed_sample);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        case (kind)
          KIND_LOAD: pcm_mem[sample_index] = sample_value;
          KIND_TRIGGER: begin
            voice_armed[trigger_ptr] = 1'b1;
            trigger_ptr = trigger_ptr + 5'd1;
          end
          KIND_TICK: expected_mix.push_back(mix_tick());
          default: ;
        endcase
      end
    end
    pending_count = expected_mix.size();
  end

endmodule

// ----- verif/one_shot_sample_voice_mixer_unit_tb.sv -----
module one_shot_sample_voice_mixer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import osvm_pkg::*;

  // Hold-off after the last result before a register write: a load or trigger
  // can still be inside the engine, and a tick walks all voices.
  localparam int DRAIN_CYCLES = 64;
  // Bound on the whole run; far above the slowest correct run.
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Words loaded before any voice plays. Every phase keeps voices below them:
  // either the sample length is short, or there are too few ticks at the
  // fast rates for a voice to walk past them.
  localparam int FILL_WORDS = 128;

  // The kind code that the block takes and drops.
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [PCM_W-1:0] PCM_MAX = 16'h7fff;
  localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  logic [1:0]               kind;
  logic [INDEX_W-1:0]       sample_index;
  logic signed [PCM_W-1:0]  sample_value;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [PCM_W-1:0]  mixed_sample;
  logic                     cfg_write;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  int fail_count;
  int pending_count;
  int cycle_count;
  bit gaps_on;

  one_shot_sample_voice_mixer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mixed_sample (mixed_sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // The checker watches both channels and the register port, predicts every
  // tick and compares; the top only drives and reads the failure and pending counts.
  voice_mix_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .sample_index  (sample_index),
    .sample_value  (sample_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .mixed_sample  (mixed_sample),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, some long ones, and now and
  // then a quiet stretch with no stall at all. Change only at the falling edge.
  initial begin
    result_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        result_stall = 1'b0;
        repeat ($urandom_range(40, 200)) @(negedge clk);
      end else begin
        result_stall = 1'b1;
        if ($urandom_range(0, 99) < 85)
          repeat ($urandom_range(1, 3)) @(negedge clk);
        else
          repeat ($urandom_range(10, 80)) @(negedge clk);
        result_stall = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // Idle cycles before the next item; none while gaps are switched off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one item at a falling edge and hold it until the block takes it.
  // Entered and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input logic [1:0] k, input logic [INDEX_W-1:0] idx,
                           input logic [PCM_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind         = k;
    sample_index = idx;
    sample_value = val;
    item_valid   = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Trigger, tick and reserved items carry random don't-care payload.
  task automatic send_bare(input logic [1:0] k);
    send_item(k, INDEX_W'($urandom_range(0, 4095)), PCM_W'($urandom));
  endtask

  // PCM word for a load: mostly random, sometimes full scale either way.
  function automatic logic [PCM_W-1:0] pick_pcm();
    case ($urandom_range(0, 15))
      0:       return PCM_MAX;
      1:       return PCM_MIN;
      default: return PCM_W'($urandom);
    endcase
  endfunction

  // Stop sending, wait until every tick has its result, then let the engine settle.
  task automatic drain_results();
    item_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [CFG_W-1:0] d);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data  = d;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic write_setting(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] lvl,
                               input logic [CFG_W-1:0] dec, input logic [CFG_W-1:0] len);
    drain_results();
    write_reg(REG_RATE_STEP, rate);
    write_reg(REG_LEVEL, lvl);
    write_reg(REG_DECAY_FACTOR, dec);
    write_reg(REG_SAMPLE_LENGTH, len);
  endtask

  // Random traffic: mostly triggers and ticks so voices start, play out and end,
  // loads that rewrite the sample under playing voices, a few reserved kinds,
  // and now and then a long run of triggers that wraps the voice pointer so one
  // voice is armed twice before a tick.
  task automatic run_random(input int count);
    int sent;
    int r;
    int burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
      r = $urandom_range(0, 99);
      if (r < 1) begin
        burst = $urandom_range(33, 40);
        repeat (burst) send_bare(KIND_TRIGGER);
        sent += burst;
      end else if (r < 46) begin
        send_bare(KIND_TICK);
        sent++;
      end else if (r < 76) begin
        send_bare(KIND_TRIGGER);
        sent++;
      end else if (r < 95) begin
        send_item(KIND_LOAD, INDEX_W'($urandom_range(0, 4095)), pick_pcm());
        sent++;
      end else begin
        send_bare(KIND_RESERVED);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] lvl,
                           input logic [CFG_W-1:0] dec, input logic [CFG_W-1:0] len,
                           input int count);
    write_setting(rate, lvl, dec, len);
    gaps_on = ($urandom_range(0, 3) != 0);
    run_random(count);
  endtask

  initial begin
    int addr;
    item_valid   = 1'b0;
    kind         = KIND_LOAD;
    sample_index = '0;
    sample_value = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_RATE_STEP;
    cfg_data     = '0;
    gaps_on      = 1'b1;
    rst          = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Fill the low words of sample memory first: no voice may ever read an unwritten word.
    for (addr = 0; addr < FILL_WORDS; addr++) begin
      send_item(KIND_LOAD, addr[INDEX_W-1:0], PCM_W'($urandom));
    end

    // Directed: full-scale words at both ends of memory, a tick with no voice,
    // two loud voices that clip high then low, a reserved kind, three more
    // triggers that start further voices, then ticks until the short sample runs out.
    write_setting(18'd65536, 18'd65535, 18'd65536, 18'd8);
    send_item(KIND_LOAD, 12'd0, PCM_MAX);
    send_item(KIND_LOAD, 12'd1, PCM_MAX);
    send_item(KIND_LOAD, 12'd2, PCM_MIN);
    send_item(KIND_LOAD, 12'd3, PCM_MIN);
    send_item(KIND_LOAD, 12'd4095, PCM_MAX);
    send_item(KIND_LOAD, 12'd4094, PCM_MIN);
    send_bare(KIND_TICK);
    send_bare(KIND_TRIGGER);
    send_bare(KIND_TRIGGER);
    send_bare(KIND_TICK);
    send_bare(KIND_TICK);
    send_bare(KIND_TICK);
    send_bare(KIND_RESERVED);
    send_bare(KIND_TRIGGER);
    send_bare(KIND_TRIGGER);
    send_bare(KIND_TRIGGER);
    repeat (9) send_bare(KIND_TICK);

    // Settings sweep; each write waits for the block to go idle, which also
    // makes the sender pause until every result is in.
    run_phase(18'd65536, 18'd8192, 18'd65536, 18'd4096, 30);   // reset values
    run_phase(18'd65536, 18'd8192, 18'd65536, 18'd16, 35);     // voices end quickly
    run_phase(18'd0, 18'd65535, 18'd60000, 18'd8, 25);         // frozen position, decay
    run_phase(18'd262143, 18'd4096, 18'd131071, 18'd8191, 20); // top rate, clamped decay/length
    run_phase(18'd1, 18'd0, 18'd0, 18'd0, 20);                 // silent, length below two
    run_phase(18'd40000, 18'd30000, 18'd65000, 18'd1, 25);     // fractional steps, length one
    run_phase(18'd98304, 18'd65535, 18'd65536, 18'd32, 30);    // many loud voices clip
    repeat (3) begin
      run_phase(CFG_W'($urandom_range(1, 131072)), CFG_W'($urandom_range(0, 65535)),
                CFG_W'($urandom_range(50000, 65536)), CFG_W'($urandom_range(2, 120)), 25);
    end

    drain_results();
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
